FILE: rtl/core/ihex_pkg.sv
// ihex_pkg: types, character constants and the hex digit function shared by
// the Intel HEX record encoder core. No dependencies.
`timescale 1ns / 1ps

package ihex_pkg;

  typedef enum logic {
    CmdHeader = 1'b0,
    CmdData   = 1'b1
  } cmd_e;

  // Input word, one item pushed by the producer.
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  record_type;
    logic [15:0] load_address;
    logic [7:0]  byte_cnt;
    logic [7:0]  payload;
  } in_item_t;

  // Output word, one character handed to the consumer.
  typedef struct packed {
    logic [6:0] ascii_char;
    logic       record_end;
  } out_item_t;

  localparam int unsigned JobBytes = 5;  // count, addr hi, addr lo, type, checksum

  // One unit of work for the character sequencer.
  typedef struct packed {
    logic                      colon;   // lead the job with ':'
    logic [2:0]                nbytes;  // bytes to print from the list below
    logic                      close;   // last byte printed is the checksum
    logic [JobBytes-1:0][7:0]  bytes;   // bytes[0] goes out first
  } job_t;

  localparam logic [6:0] CharColon = 7'h3A;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharUpA   = 7'h41;
  localparam logic [3:0] NibTen    = 4'hA;

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] c;
    if (nib >= NibTen) begin
      c = CharUpA + {3'b000, nib - NibTen};
    end else begin
      c = CharZero + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/ihex_front.sv
// ihex_front: accepts input words, tracks the open record and the running
// sum, and turns each word into a job for the sequencer. Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,   // word taken this cycle
  input  ihex_pkg::in_item_t item_i,
  output logic               job_valid_o,
  output ihex_pkg::job_t     job_o
);

  logic [7:0] sum_q, sum_d;
  logic [7:0] left_q, left_d;
  logic       open_q, open_d;

  logic       is_header;
  logic [7:0] hdr_sum;
  logic [7:0] dat_sum;
  logic [7:0] dat_left;
  logic       hdr_close;
  logic       dat_close;

  assign is_header = (item_i.cmd == ihex_pkg::CmdHeader);
  assign hdr_sum   = item_i.byte_cnt + item_i.load_address[15:8]
                   + item_i.load_address[7:0] + item_i.record_type;
  assign dat_sum   = sum_q + item_i.payload;
  assign dat_left  = left_q - 8'd1;
  assign hdr_close = (item_i.byte_cnt == 8'd0);
  assign dat_close = (dat_left == 8'd0);

  // data words with no record open are dropped here
  assign job_valid_o = is_header || open_q;

  always_comb begin
    job_o = '0;
    if (is_header) begin
      job_o.colon    = 1'b1;
      job_o.close    = hdr_close;
      job_o.nbytes   = hdr_close ? 3'd5 : 3'd4;
      job_o.bytes[0] = item_i.byte_cnt;
      job_o.bytes[1] = item_i.load_address[15:8];
      job_o.bytes[2] = item_i.load_address[7:0];
      job_o.bytes[3] = item_i.record_type;
      job_o.bytes[4] = 8'd0 - hdr_sum;
    end else begin
      job_o.colon    = 1'b0;
      job_o.close    = dat_close;
      job_o.nbytes   = dat_close ? 3'd2 : 3'd1;
      job_o.bytes[0] = item_i.payload;
      job_o.bytes[1] = 8'd0 - dat_sum;
    end
  end

  always_comb begin
    sum_d  = sum_q;
    left_d = left_q;
    open_d = open_q;
    if (accept_i && is_header) begin
      sum_d  = hdr_close ? 8'd0 : hdr_sum;
      left_d = item_i.byte_cnt;
      open_d = !hdr_close;
    end else if (accept_i && open_q) begin
      sum_d  = dat_close ? 8'd0 : dat_sum;
      left_d = dat_left;
      open_d = !dat_close;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= 8'd0;
      left_q <= 8'd0;
      open_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      left_q <= left_d;
      open_q <= open_d;
    end
  end

endmodule

FILE: rtl/core/ihex_job_fifo.sv
// ihex_job_fifo: short register queue of jobs between front and sequencer.
// Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_job_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  ihex_pkg::job_t wr_job_i,
  input  logic           rd_i,
  output ihex_pkg::job_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ihex_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ihex_back.sv
// ihex_back: character sequencer; walks the head job one character per cycle
// into the output register unless the output stalls. Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_avail_i,
  input  ihex_pkg::job_t      job_i,
  output logic                job_done_o,
  output logic                empty_o,
  input  logic                pop_i,
  output ihex_pkg::out_item_t item_o
);

  logic [3:0]          pos_q, pos_d;
  logic                out_valid_q, out_valid_d;
  ihex_pkg::out_item_t out_q;
  ihex_pkg::out_item_t cur;

  logic       advance;
  logic [3:0] total;
  logic       last;
  logic [3:0] k;
  logic [7:0] cur_byte;
  logic [3:0] nib;

  assign advance = job_avail_i && (!out_valid_q || pop_i);
  assign total   = 4'(job_i.colon) + {job_i.nbytes, 1'b0};
  assign last    = (pos_q == total - 4'd1);
  assign k       = pos_q - 4'(job_i.colon);

  always_comb begin
    case (k[3:1])
      3'd0:    cur_byte = job_i.bytes[0];
      3'd1:    cur_byte = job_i.bytes[1];
      3'd2:    cur_byte = job_i.bytes[2];
      3'd3:    cur_byte = job_i.bytes[3];
      3'd4:    cur_byte = job_i.bytes[4];
      default: cur_byte = 8'd0;
    endcase
  end

  assign nib = k[0] ? cur_byte[3:0] : cur_byte[7:4];

  always_comb begin
    if (job_i.colon && (pos_q == 4'd0)) begin
      cur.ascii_char = ihex_pkg::CharColon;
    end else begin
      cur.ascii_char = ihex_pkg::hex_digit(nib);
    end
    cur.record_end = last && job_i.close;
  end

  assign job_done_o = advance && last;

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      pos_d       = last ? 4'd0 : pos_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

endmodule

FILE: rtl/core/intel_hex_record_encoder_core.sv
// Intel HEX record encoder core: front, job queue and character sequencer.
// Path: pushed word -> job queue register -> output register (first character).
// Throughput: one character per cycle while pop keeps up, set by the single
//   output register; a data byte is 2 chars (4 if closing), a header 9 or 11.
// Reset: rst_ni is asynchronous, active low, and empties queue and output.
// Depends on ihex_pkg, ihex_front, ihex_job_fifo, ihex_back.
`timescale 1ns / 1ps

module intel_hex_record_encoder_core #(
  parameter int unsigned JobDepth = 4  // queued jobs between front and back, >= 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input word queue side
  input  logic                push,
  output logic                full,
  input  ihex_pkg::in_item_t  in_item_i,
  // output word queue side
  output logic                empty,
  input  logic                pop,
  output ihex_pkg::out_item_t out_item_o
);

  logic           accept;
  logic           job_valid;
  ihex_pkg::job_t front_job;
  ihex_pkg::job_t head_job;
  logic           fifo_full;
  logic           fifo_empty;
  logic           job_done;

  // An input word is taken whenever the job queue has room, even if it is
  // a stray data word that the front then drops.
  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  // Front: keeps running sum / bytes left / open flag, builds the job,
  // including the precomputed checksum when this word closes the record.
  ihex_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (front_job)
  );

  // Queue decouples word intake from character output.
  ihex_job_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept && job_valid),
    .wr_job_i (front_job),
    .rd_i     (job_done),
    .head_o   (head_job),
    .full_o   (fifo_full),
    .empty_o  (fifo_empty)
  );

  // Back: one character per cycle from the head job unless output stalls; retires
  // the job on its last character.
  ihex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!fifo_empty),
    .job_i       (head_job),
    .job_done_o  (job_done),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

endmodule

FILE: rtl/core/ihex_checker.sv
// ihex_checker: port-level assertions for the encoder core, bound to the top.
// Uses ihex_pkg.
`timescale 1ns / 1ps

module ihex_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input ihex_pkg::out_item_t out_item_o
);

  logic       after_end_q;
  logic [6:0] ch;

  assign ch = out_item_o.ascii_char;

  // a closed record is always followed by a new ':'
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_end_q <= 1'b0;
    end else if (pop && !empty) begin
      after_end_q <= out_item_o.record_end;
    end
  end

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (ch == ihex_pkg::CharColon) ||
               (ch >= 7'h30 && ch <= 7'h39) || (ch >= 7'h41 && ch <= 7'h46))
    else $error("output word is not ':' or an upper-case hex digit");

  a_end_not_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.record_end |-> ch != ihex_pkg::CharColon)
    else $error("record end flagged on a ':'");

  a_colon_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && after_end_q |-> ch == ihex_pkg::CharColon)
    else $error("record did not restart with ':' after a checksum");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("stalled output word changed");

endmodule

bind intel_hex_record_encoder_core ihex_checker u_ihex_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

FILE: bench/ihex_stream_checker.sv
// ihex_stream_checker: watches both queue sides of the Intel HEX encoder,
// predicts the character stream and compares it. Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_stream_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  ihex_pkg::in_item_t  in_item_i,
  input  logic                empty,
  input  logic                pop,
  input  ihex_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  ihex_pkg::out_item_t char_q[$];  // characters still owed by the block

  logic [7:0] rec_sum;
  logic [7:0] rec_left;
  logic       rec_open;
  int         n_fail = 0;
  int         n_chars = 0;

  function automatic logic [6:0] nibble_char(input logic [3:0] nib);
    if (nib >= ihex_pkg::NibTen) return ihex_pkg::CharUpA + 7'(nib - ihex_pkg::NibTen);
    return ihex_pkg::CharZero + 7'(nib);
  endfunction

  task automatic owe_byte(input logic [7:0] b, input logic last);
    char_q.push_back({nibble_char(b[7:4]), 1'b0});
    char_q.push_back({nibble_char(b[3:0]), last});
  endtask

  // checksum is the two's complement of the running sum
  task automatic close_record();
    owe_byte(~rec_sum + 8'd1, 1'b1);
    rec_sum  = '0;
    rec_left = '0;
    rec_open = 1'b0;
  endtask

  task automatic predict_word(input ihex_pkg::in_item_t w);
    if (w.cmd == ihex_pkg::CmdHeader) begin
      // a header always starts afresh, even over an open record
      char_q.push_back({ihex_pkg::CharColon, 1'b0});
      owe_byte(w.byte_cnt, 1'b0);
      owe_byte(w.load_address[15:8], 1'b0);
      owe_byte(w.load_address[7:0], 1'b0);
      owe_byte(w.record_type, 1'b0);
      rec_sum  = w.byte_cnt + w.load_address[15:8] + w.load_address[7:0] + w.record_type;
      rec_left = w.byte_cnt;
      rec_open = 1'b1;
      if (rec_left == 8'd0) close_record();
    end else if (rec_open) begin
      owe_byte(w.payload, 1'b0);
      rec_sum  = rec_sum + w.payload;
      rec_left = rec_left - 8'd1;
      if (rec_left == 8'd0) close_record();
    end
    // data with no open record is dropped
  endtask

  task automatic check_char(input ihex_pkg::out_item_t got);
    ihex_pkg::out_item_t want;
    n_chars++;
    if (char_q.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("[%0t] char %0d unexpected: got 0x%h end %b",
                 $realtime, n_chars, got.ascii_char, got.record_end);
    end else begin
      want = char_q.pop_front();
      if (want.ascii_char != got.ascii_char || want.record_end != got.record_end) begin
        n_fail++;
        if (n_fail <= 10)
          $display("[%0t] char %0d mismatch: expected 0x%h end %b, got 0x%h end %b",
                   $realtime, n_chars, want.ascii_char, want.record_end,
                   got.ascii_char, got.record_end);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q.delete();
      rec_sum   = '0;
      rec_left  = '0;
      rec_open  = 1'b0;
      pending_o <= 0;
      fail_count_o <= n_fail;
    end else begin
      if (pop && !empty) check_char(out_item_i);
      if (push && !full) predict_word(in_item_i);
      pending_o    <= char_q.size();
      fail_count_o <= n_fail;
    end
  end

endmodule

FILE: bench/tb_intel_hex_record_encoder_core.sv
// tb_intel_hex_record_encoder_core: drives headers and data bytes into the
// encoder and pops characters; ihex_stream_checker judges. Needs ihex_pkg.
`timescale 1ns / 1ps

module tb_intel_hex_record_encoder_core;

  localparam int WordTarget = 340;     // words in the random part
  localparam int CalmFrom   = 280;     // no idling from here on
  localparam int HoldCycles = 400;     // long consumer hold-off
  localparam int CycleLimit = 400000;  // watchdog
  localparam int TailCycles = 20;      // quiet time after the last char

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                push    = 1'b0;
  logic                pop     = 1'b0;
  ihex_pkg::in_item_t  in_item = '0;
  logic                full;
  logic                empty;
  ihex_pkg::out_item_t out_item;

  int fail_count;
  int pending;

  // shared knobs between the producer and consumer processes
  logic calm     = 1'b0;  // set for the tail of the run: no idling at all
  logic hold_req = 1'b0;  // one-shot request for a long consumer hold-off
  int   gap_pct  = 0;     // producer idle chance per word, re-picked per phase

  always #1 clk_i = ~clk_i;

  intel_hex_record_encoder_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  ihex_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item),
    .empty        (empty),
    .pop          (pop),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Word builders: fields a word's cmd does not read get random junk so the
  // block is shown to ignore them.
  function automatic ihex_pkg::in_item_t header_word(input logic [7:0] rtype,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] cnt);
    ihex_pkg::in_item_t w;
    w.cmd          = ihex_pkg::CmdHeader;
    w.record_type  = rtype;
    w.load_address = addr;
    w.byte_cnt     = cnt;
    w.payload      = 8'($urandom);
    return w;
  endfunction

  function automatic ihex_pkg::in_item_t data_word(input logic [7:0] b);
    ihex_pkg::in_item_t w;
    w.cmd          = ihex_pkg::CmdData;
    w.record_type  = 8'($urandom);
    w.load_address = 16'($urandom);
    w.byte_cnt     = 8'($urandom);
    w.payload      = b;
    return w;
  endfunction

  // Offer one word and return at the edge that takes it. push stays high on
  // return so back-to-back words see no bubble; an idle burst lowers it first.
  task automatic send_word(input ihex_pkg::in_item_t w);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Stop offering and wait for every owed character to come out.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Header followed by n of its data bytes (n may fall short of cnt).
  task automatic send_record(input logic [7:0] cnt, input int n);
    send_word(header_word(8'($urandom), 16'($urandom), cnt));
    for (int k = 0; k < n; k++) send_word(data_word(8'($urandom)));
  endtask

  // Consumer: pops with random stall bursts; honors the long hold-off.
  initial begin
    int stall_pct;
    int seg_left;
    stall_pct = 0;
    seg_left  = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (seg_left == 0) begin
        // some phases stall a lot, some not at all
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
        seg_left  = 64;
      end
      seg_left--;
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Watchdog: a stuck handshake or a missing char ends here.
  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Producer and verdict.
  initial begin
    int words;
    int recs;
    int pick;
    int cnt;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 20;

    // --- directed ---
    send_word(data_word(8'h5A));                     // data before any header: dropped
    send_word(header_word(8'h00, 16'h0000, 8'd0));   // zero count, all-zero fields
    send_word(header_word(8'hFF, 16'hFFFF, 8'd0));   // zero count, all-ones fields
    send_word(header_word(8'h00, 16'h8000, 8'd1));
    send_word(data_word(8'h00));
    send_word(header_word(8'h01, 16'h00FF, 8'd2));
    send_word(data_word(8'hFF));
    send_word(data_word(8'hA5));
    send_word(header_word(8'h04, 16'h1234, 8'd255)); // max count, abandoned early
    send_word(data_word(8'h3C));
    send_word(header_word(8'h02, 16'hFF00, 8'd1));   // new header drops the open record
    send_word(data_word(8'h80));
    send_word(data_word(8'h77));                     // after checksum: dropped
    send_word(header_word(8'h05, 16'hABCD, 8'd3));
    send_word(data_word(8'h01));
    send_word(data_word(8'h02));
    send_word(header_word(8'h03, 16'h5AA5, 8'd0));   // abandons with one byte short
    send_word(data_word(8'hC3));                     // dropped again
    drain();

    // --- random ---
    words = 0;
    recs  = 0;
    while (words < WordTarget) begin
      if (words >= CalmFrom) calm = 1'b1;
      if (recs % 8 == 0)
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      if (recs == 15) hold_req = 1'b1;  // producer keeps offering: block fills
      if (recs == 40 || recs == 90) drain();

      pick = $urandom_range(0, 99);
      if (pick < 70)      cnt = $urandom_range(0, 4);
      else if (pick < 95) cnt = $urandom_range(5, 16);
      else                cnt = $urandom_range(17, 40);

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // stray data: dropped, or eats into a record left open
        send_word(data_word(8'($urandom)));
        words++;
      end else if (pick < 20 && cnt > 0) begin
        // short record, later abandoned by the next header
        pick = $urandom_range(0, cnt - 1);
        send_record(8'(cnt), pick);
        words += pick + 1;
      end else begin
        send_record(8'(cnt), cnt);
        words += cnt + 1;
      end
      recs++;
    end

    // --- wind down ---
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
